[src/fpsa_pkg.sv]
// fpsa_pkg: shared constants, status codes and controller states of the page allocator
`default_nettype none
package fpsa_pkg;

  // stack geometry
  localparam int PAGE_SLOTS = 2048;
  localparam int SLOT_W     = $clog2(PAGE_SLOTS);
  localparam int TOP_W      = $clog2(PAGE_SLOTS + 1);

  // field widths
  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int PNUM_W     = ADDR_W - PAGE_SHIFT;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 12;

  // side bitmap of held pages, one bit per page number, packed into rows
  localparam int BM_WORD = 32;
  localparam int BIT_W   = $clog2(BM_WORD);
  localparam int ROW_W   = PNUM_W - BIT_W;
  localparam int BM_ROWS = (1 << PNUM_W) / BM_WORD;

  // request kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DUP   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_BITS,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[src/fpsa_req_if.sv]
// fpsa_req_if: request channel carrying mode and byte address
`default_nettype none
interface fpsa_req_if;
  import fpsa_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output mode, output address, input ready);
  modport sink   (input valid, input mode, input address, output ready);
endinterface
`default_nettype wire

[src/fpsa_rsp_if.sv]
// fpsa_rsp_if: result channel carrying page address, status and free count
`default_nettype none
interface fpsa_rsp_if;
  import fpsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   page_address;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  free_count;

  modport source (output valid, output page_address, output status, output free_count,
                  input ready);
  modport sink   (input valid, input page_address, input status, input free_count,
                  output ready);
endinterface
`default_nettype wire

[src/free_page_stack_allocator.sv]
// free_page_stack_allocator: free page stack with bitmap duplicate check
//
// Requests arrive on req (mode, address); one result per request leaves on rsp
// (page_address, status, free_count). Allocate pops the top page number; free
// masks the address to its page and pushes it unless already held or the
// stack is full. A 1-bit-per-page bitmap in a second ram answers "already held".
// A successful allocate steps through a stack read, a bitmap read and a bitmap
// write, a free through a bitmap read and its update, and an allocate on an empty
// stack goes straight to the result. One request is worked at a time; the
// next request is taken the cycle after the result is loaded. The result sits
// in an output register: a stalled receiver holds it there, and only the
// following request waits behind it. After reset the stack is empty and the
// bitmap is swept to zero, one 32-bit row a cycle over all BM_ROWS = 32768
// rows; req.ready stays low during the sweep.
`default_nettype none
module free_page_stack_allocator (
  input wire logic clk,
  input wire logic rst,
  fpsa_req_if.sink   req,
  fpsa_rsp_if.source rsp
);
  import fpsa_pkg::*;

  state_t state, state_next;

  // control and datapath registers
  logic [TOP_W-1:0]  top;
  logic [ROW_W-1:0]  clr_row;
  logic              cur_mode;
  logic [PNUM_W-1:0] pnum;
  logic [ADDR_W-1:0] res_page;
  status_t           res_status;

  // output register
  logic                rsp_valid;
  logic [ADDR_W-1:0]   rsp_page;
  logic [STATUS_W-1:0] rsp_status;
  logic [COUNT_W-1:0]  rsp_count;

  // memory ports
  logic              stack_we;
  logic [SLOT_W-1:0] stack_waddr, stack_raddr;
  logic [PNUM_W-1:0] stack_wdata, stack_rdata;
  logic              bm_we;
  logic [ROW_W-1:0]  bm_waddr, bm_raddr;
  logic [BM_WORD-1:0] bm_wdata, bm_rdata;

  // decode helpers
  logic              accept;
  logic              out_free;
  logic              clr_last;
  logic              stack_empty;
  logic              stack_full;
  logic              held;
  logic [TOP_W-1:0]  top_dec;
  logic [PNUM_W-1:0] req_pnum;

  assign accept      = req.valid && req.ready;
  assign out_free    = !rsp_valid || rsp.ready;
  assign clr_last    = (clr_row == ROW_W'(BM_ROWS - 1));
  assign stack_empty = (top == '0);
  assign stack_full  = (top == TOP_W'(PAGE_SLOTS));
  assign top_dec     = top - TOP_W'(1);
  assign req_pnum    = req.address[ADDR_W-1:PAGE_SHIFT];
  assign held        = bm_rdata[pnum[BIT_W-1:0]];

  // stack of free page numbers
  fpsa_ram #(
    .WIDTH (PNUM_W),
    .DEPTH (PAGE_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  // bitmap of pages currently on the stack
  fpsa_ram #(
    .WIDTH (BM_WORD),
    .DEPTH (BM_ROWS)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (req.mode == MODE_FREE) state_next = S_BITS;
          else if (stack_empty)      state_next = S_DONE;
          else                       state_next = S_LOOK;
        end
      end
      S_LOOK:  state_next = S_BITS;
      S_BITS:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    req.ready   = 1'b0;
    stack_we    = 1'b0;
    stack_waddr = top[SLOT_W-1:0];
    stack_wdata = pnum;
    stack_raddr = top_dec[SLOT_W-1:0];
    bm_we       = 1'b0;
    bm_waddr    = pnum[PNUM_W-1:BIT_W];
    bm_wdata    = bm_rdata;
    bm_raddr    = req_pnum[PNUM_W-1:BIT_W];
    unique case (state)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_row;
        bm_wdata = '0;
      end
      S_IDLE: begin
        req.ready = 1'b1;
      end
      S_LOOK: begin
        // popped page number is on the stack read port now
        bm_raddr = stack_rdata[PNUM_W-1:BIT_W];
      end
      S_BITS: begin
        if (cur_mode == MODE_ALLOC) begin
          bm_we                      = 1'b1;
          bm_wdata[pnum[BIT_W-1:0]]  = 1'b0;
        end else if (!held && !stack_full) begin
          bm_we                      = 1'b1;
          bm_wdata[pnum[BIT_W-1:0]]  = 1'b1;
          stack_we                   = 1'b1;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control state and per-request datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      top     <= '0;
      clr_row <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr_row <= clr_row + ROW_W'(1);
        S_IDLE: begin
          if (accept) begin
            cur_mode   <= req.mode;
            pnum       <= req_pnum;
            res_page   <= '0;
            res_status <= (req.mode == MODE_ALLOC && stack_empty) ? ST_EMPTY : ST_OK;
          end
        end
        S_LOOK: pnum <= stack_rdata;
        S_BITS: begin
          if (cur_mode == MODE_ALLOC) begin
            top      <= top_dec;
            res_page <= {pnum, {PAGE_SHIFT{1'b0}}};
          end else if (held) begin
            res_status <= ST_DUP;
          end else if (stack_full) begin
            res_status <= ST_FULL;
          end else begin
            top <= top + TOP_W'(1);
          end
        end
        S_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid  <= 1'b1;
      rsp_page   <= res_page;
      rsp_status <= res_status;
      rsp_count  <= COUNT_W'(top);
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.page_address = rsp_page;
  assign rsp.status       = rsp_status;
  assign rsp.free_count   = rsp_count;

`ifndef SYNTH
  // stack pointer never passes the slot count
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    top <= TOP_W'(PAGE_SLOTS))
    else $error("stack pointer beyond slot count");

  // allocate on an empty stack goes straight to the result with empty status
  a_empty_alloc: assert property (@(posedge clk) disable iff (rst)
    (accept && req.mode == MODE_ALLOC && stack_empty)
      |=> (state == S_DONE && res_status == ST_EMPTY))
    else $error("empty allocate not reported");

  // every push moves the pointer up by one
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    stack_we |=> (top == $past(top) + TOP_W'(1)))
    else $error("push without pointer increment");

  // bitmap is written only by the sweep or the update step
  a_bm_write: assert property (@(posedge clk) disable iff (rst)
    bm_we |-> (state == S_CLEAR || state == S_BITS))
    else $error("bitmap write outside sweep or update");

  // results always carry a page-aligned address
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_page[PAGE_SHIFT-1:0] == '0))
    else $error("result address not page aligned");
`endif

endmodule
`default_nettype wire

[src/fpsa_ram.sv]
// fpsa_ram: generic simple dual-port ram with registered read
`default_nettype none
module fpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
